// File: rtl/video_frame_packet_reassembler_top_macros.svh
// Assertion macros for the frame packet reassembler.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef VIDEO_FRAME_PACKET_REASSEMBLER_TOP_MACROS_SVH
`define VIDEO_FRAME_PACKET_REASSEMBLER_TOP_MACROS_SVH

// Plain property check, sampled on the rising clock, off during reset.
`define VFPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define VFPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `VFPR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/vfpr_pkg.sv
// Shared types and constants of the frame packet reassembler.
// No dependencies; used by video_frame_packet_reassembler_top.
package vfpr_pkg;

  localparam int unsigned MAX_TRANSFER = 1048576;
  localparam int unsigned REQ_W        = 21;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned BYTES_W      = 48;

  localparam logic [1:0] CFG_FRAME_BYTES = 2'd0;
  localparam logic [1:0] CFG_CHUNK_BYTES = 2'd1;
  localparam logic [1:0] CFG_TAIL_BYTES  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_TRAILER = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLOSE_SUCCESS  = 2'd0,
    CLOSE_MISSING  = 2'd1,
    CLOSE_MISMATCH = 2'd2
  } close_e;

  // Input beat, lowest bit first: byte_count, transfer_failed, buffer_ready.
  typedef struct packed {
    logic             pad;
    logic             buffer_ready;
    logic             transfer_failed;
    logic [REQ_W-1:0] byte_count;
  } in_beat_t;

  // Result beat, lowest bit first.
  typedef struct packed {
    logic [5:0]         pad;
    logic [BYTES_W-1:0] bytes_dropped;
    logic [BYTES_W-1:0] bytes_taken;
    logic [CNT_W-1:0]   underruns;
    logic [CNT_W-1:0]   bad_frames;
    logic [CNT_W-1:0]   good_frames;
    logic [REQ_W-1:0]   next_request;
    close_e             close_status;
    logic               frame_closed;
    logic               frame_opened;
    logic [31:0]        store_offset;
    logic               store_data;
  } out_beat_t;

endpackage

// File: rtl/video_frame_packet_reassembler_top.sv
// Frame reassembler for a leader / data / trailer transfer stream.
// Depends on vfpr_pkg and video_frame_packet_reassembler_top_macros.svh.
//
// One beat per received transfer goes in and one result beat comes out. The block takes a new
// beat every cycle while the output is not stalled; a result passes through the input
// register, then the frame state update and the result register. The frame state and
// counters are updated once per accepted beat. A stalled output holds the result register,
// and the input register too once it holds a beat, and then drops tready. Registers: 0 frame
// size, 1 chunk size, 2 trailer request size; write them only while no beat is in flight.
`include "video_frame_packet_reassembler_top_macros.svh"

module video_frame_packet_reassembler_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [23:0]  s_axis_tdata_i,  // byte_count[20:0], transfer_failed, buffer_ready, pad
  input  logic [1:0]   s_axis_tuser_i,  // packet_kind[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o,  // store_data, store_offset[31:0], frame_opened,
                                        // frame_closed, close_status[1:0],
                                        // next_request[20:0], good_frames[31:0],
                                        // bad_frames[31:0], underruns[31:0],
                                        // bytes_taken[47:0], bytes_dropped[47:0], pad
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  // configuration
  logic [31:0]                 frame_bytes_q;
  logic [vfpr_pkg::REQ_W-1:0]  chunk_bytes_q;
  logic [vfpr_pkg::REQ_W-1:0]  tail_bytes_q;

  // pipeline
  logic                 in_valid_q;
  vfpr_pkg::in_beat_t   in_q;
  vfpr_pkg::kind_e      in_kind_q;
  logic                 out_valid_q;
  vfpr_pkg::out_beat_t  out_q, out_d;
  logic                 s_hs, adv;

  // frame state
  logic                          open_q, open_d;
  logic                          mismatch_q, mismatch_d;
  logic [31:0]                   fill_q, fill_d;
  logic [vfpr_pkg::CNT_W-1:0]    good_q, good_d;
  logic [vfpr_pkg::CNT_W-1:0]    bad_q, bad_d;
  logic [vfpr_pkg::CNT_W-1:0]    under_q, under_d;
  logic [vfpr_pkg::BYTES_W-1:0]  taken_q, taken_d;
  logic [vfpr_pkg::BYTES_W-1:0]  dropped_q, dropped_d;

  logic [32:0]                   fill_sum;
  logic                          fits;
  logic [31:0]                   left;
  logic                          store_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= 32'(vfpr_pkg::MAX_TRANSFER);
      chunk_bytes_q <= vfpr_pkg::REQ_W'(vfpr_pkg::MAX_TRANSFER);
      tail_bytes_q  <= vfpr_pkg::REQ_W'(1024);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vfpr_pkg::CFG_FRAME_BYTES: frame_bytes_q <= cfg_data_i;
        vfpr_pkg::CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i[vfpr_pkg::REQ_W-1:0];
        vfpr_pkg::CFG_TAIL_BYTES:  tail_bytes_q  <= cfg_data_i[vfpr_pkg::REQ_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the input beat whenever the result register is free or being drained
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      in_q      <= vfpr_pkg::in_beat_t'(s_axis_tdata_i);
      in_kind_q <= vfpr_pkg::kind_e'(s_axis_tuser_i);
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign fill_sum = {1'b0, fill_q} + 33'(in_q.byte_count);
  assign fits     = fill_sum <= {1'b0, frame_bytes_q};

  always_comb begin
    open_d     = open_q;
    mismatch_d = mismatch_q;
    fill_d     = fill_q;
    good_d     = good_q;
    bad_d      = bad_q;
    under_d    = under_q;
    taken_d    = taken_q;
    dropped_d  = dropped_q;
    out_d      = '0;
    store_c    = 1'b0;
    if (!in_q.transfer_failed) begin
      unique case (in_kind_q)
        vfpr_pkg::KIND_LEADER: begin
          // hand out the frame still open as missing packets
          if (open_q) begin
            out_d.frame_closed = 1'b1;
            out_d.close_status = vfpr_pkg::CLOSE_MISSING;
            bad_d              = bad_q + vfpr_pkg::CNT_W'(1);
            open_d             = 1'b0;
          end
          if (in_q.buffer_ready) begin
            open_d             = 1'b1;
            mismatch_d         = 1'b0;
            fill_d             = '0;
            out_d.frame_opened = 1'b1;
            taken_d            = taken_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
          end else begin
            under_d   = under_q + vfpr_pkg::CNT_W'(1);
            dropped_d = dropped_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
          end
        end
        vfpr_pkg::KIND_DATA: begin
          if (open_q && !mismatch_q && fits) begin
            store_c            = 1'b1;
            out_d.store_data   = 1'b1;
            out_d.store_offset = fill_q;
            fill_d             = fill_sum[31:0];
            taken_d            = taken_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
          end else begin
            if (open_q && !mismatch_q) begin
              mismatch_d = 1'b1;
            end
            dropped_d = dropped_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
          end
        end
        vfpr_pkg::KIND_TRAILER: begin
          if (open_q) begin
            out_d.frame_closed = 1'b1;
            open_d             = 1'b0;
            if (fill_q != frame_bytes_q) begin
              out_d.close_status = vfpr_pkg::CLOSE_MISMATCH;
              bad_d              = bad_q + vfpr_pkg::CNT_W'(1);
              dropped_d          = dropped_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
            end else begin
              out_d.close_status = vfpr_pkg::CLOSE_SUCCESS;
              good_d             = good_q + vfpr_pkg::CNT_W'(1);
              taken_d            = taken_q + vfpr_pkg::BYTES_W'(in_q.byte_count);
            end
          end
        end
        vfpr_pkg::KIND_OTHER: ;
      endcase
    end

    // next request follows the updated state
    left = frame_bytes_q - fill_d;
    if (!open_d) begin
      out_d.next_request = vfpr_pkg::REQ_W'(vfpr_pkg::MAX_TRANSFER);
    end else if (fill_d < frame_bytes_q) begin
      out_d.next_request = ({11'b0, chunk_bytes_q} < left) ? chunk_bytes_q
                                                           : left[vfpr_pkg::REQ_W-1:0];
    end else begin
      out_d.next_request = tail_bytes_q;
    end

    out_d.good_frames   = good_d;
    out_d.bad_frames    = bad_d;
    out_d.underruns     = under_d;
    out_d.bytes_taken   = taken_d;
    out_d.bytes_dropped = dropped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      mismatch_q <= 1'b0;
      fill_q     <= '0;
      good_q     <= '0;
      bad_q      <= '0;
      under_q    <= '0;
      taken_q    <= '0;
      dropped_q  <= '0;
    end else if (adv) begin
      open_q     <= open_d;
      mismatch_q <= mismatch_d;
      fill_q     <= fill_d;
      good_q     <= good_d;
      bad_q      <= bad_d;
      under_q    <= under_d;
      taken_q    <= taken_d;
      dropped_q  <= dropped_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  `VFPR_ASSERT_IMPL(a_store_needs_open, store_c, open_q && !mismatch_q, "data stored without a clean open frame")
  `VFPR_ASSERT_IMPL(a_status_idle, out_valid_q && !out_q.frame_closed, out_q.close_status == vfpr_pkg::CLOSE_SUCCESS, "close status set without a close")
  `VFPR_ASSERT_IMPL(a_no_close_when_shut, adv && !open_q, !out_d.frame_closed, "frame closed while none was open")
  `VFPR_ASSERT_IMPL(a_hold_when_stalled, !adv, 1'b1 ##1 ($stable(good_q) && $stable(fill_q) && $stable(open_q)), "frame state moved without a beat")

endmodule

// File: tb/sv/tb_video_frame_packet_reassembler_top.sv
// Self-checking testbench for video_frame_packet_reassembler_top.
// Depends on vfpr_pkg and the RTL top; predicts each result beat in a small scoreboard class
// and compares it field by field while both stream sides idle at random (not in the last phase).
module tb_video_frame_packet_reassembler_top;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  class reassembly_scoreboard;
    logic [31:0]                  frame_size;
    logic [vfpr_pkg::REQ_W-1:0]   chunk_size;
    logic [vfpr_pkg::REQ_W-1:0]   tail_size;
    bit                           is_open;
    bit                           is_mismatch;
    logic [31:0]                  offset;
    logic [vfpr_pkg::CNT_W-1:0]   good;
    logic [vfpr_pkg::CNT_W-1:0]   bad;
    logic [vfpr_pkg::CNT_W-1:0]   under;
    logic [vfpr_pkg::BYTES_W-1:0] taken;
    logic [vfpr_pkg::BYTES_W-1:0] dropped;
    vfpr_pkg::out_beat_t          pending_results[$];
    int unsigned                  errors;

    function new();
      frame_size  = 32'd1048576;
      chunk_size  = 21'd1048576;
      tail_size   = 21'd1024;
      is_open     = 1'b0;
      is_mismatch = 1'b0;
      offset      = '0;
      good        = '0;
      bad         = '0;
      under       = '0;
      taken       = '0;
      dropped     = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        vfpr_pkg::CFG_FRAME_BYTES: frame_size = val;
        vfpr_pkg::CFG_CHUNK_BYTES: chunk_size = val[vfpr_pkg::REQ_W-1:0];
        vfpr_pkg::CFG_TAIL_BYTES:  tail_size  = val[vfpr_pkg::REQ_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [vfpr_pkg::REQ_W-1:0] request_size();
      logic [32:0] left;
      logic [32:0] r;
      if (!is_open) begin
        r = 33'(vfpr_pkg::MAX_TRANSFER);
      end else if (offset < frame_size) begin
        left = {1'b0, frame_size} - {1'b0, offset};
        r = ({12'b0, chunk_size} < left) ? {12'b0, chunk_size} : left;
      end else begin
        r = {12'b0, tail_size};
      end
      if (r > 33'h1FFFFF) r = 33'h1FFFFF;
      return r[vfpr_pkg::REQ_W-1:0];
    endfunction

    function bit frame_filled();
      return is_open && (offset >= frame_size);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_transfer(vfpr_pkg::kind_e kind, logic [vfpr_pkg::REQ_W-1:0] count,
                                logic failed, logic ready);
      vfpr_pkg::out_beat_t e;
      logic [32:0]         end_off;
      e = '0;
      if (!failed) begin
        case (kind)
          vfpr_pkg::KIND_LEADER: begin
            if (is_open) begin
              e.frame_closed = 1'b1;
              e.close_status = vfpr_pkg::CLOSE_MISSING;
              bad            = bad + vfpr_pkg::CNT_W'(1);
              is_open        = 1'b0;
            end
            if (ready) begin
              is_open        = 1'b1;
              is_mismatch    = 1'b0;
              offset         = '0;
              e.frame_opened = 1'b1;
              taken          = taken + vfpr_pkg::BYTES_W'(count);
            end else begin
              under   = under + vfpr_pkg::CNT_W'(1);
              dropped = dropped + vfpr_pkg::BYTES_W'(count);
            end
          end
          vfpr_pkg::KIND_DATA: begin
            if (is_open && !is_mismatch) begin
              end_off = {1'b0, offset} + 33'(count);
              if (end_off <= {1'b0, frame_size}) begin
                e.store_data   = 1'b1;
                e.store_offset = offset;
                offset         = end_off[31:0];
                taken          = taken + vfpr_pkg::BYTES_W'(count);
              end else begin
                is_mismatch = 1'b1;
                dropped     = dropped + vfpr_pkg::BYTES_W'(count);
              end
            end else begin
              dropped = dropped + vfpr_pkg::BYTES_W'(count);
            end
          end
          vfpr_pkg::KIND_TRAILER: begin
            if (is_open) begin
              e.frame_closed = 1'b1;
              if (offset != frame_size) begin
                e.close_status = vfpr_pkg::CLOSE_MISMATCH;
                bad            = bad + vfpr_pkg::CNT_W'(1);
                dropped        = dropped + vfpr_pkg::BYTES_W'(count);
              end else begin
                e.close_status = vfpr_pkg::CLOSE_SUCCESS;
                good           = good + vfpr_pkg::CNT_W'(1);
                taken          = taken + vfpr_pkg::BYTES_W'(count);
              end
              is_open = 1'b0;
            end
          end
          default: ;
        endcase
      end
      e.next_request  = request_size();
      e.good_frames   = good;
      e.bad_frames    = bad;
      e.underruns     = under;
      e.bytes_taken   = taken;
      e.bytes_dropped = dropped;
      pending_results.push_back(e);
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(vfpr_pkg::out_beat_t got);
      vfpr_pkg::out_beat_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing got %h", $time, got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare("store_data", e.store_data, got.store_data);
      compare("store_offset", e.store_offset, got.store_offset);
      compare("frame_opened", e.frame_opened, got.frame_opened);
      compare("frame_closed", e.frame_closed, got.frame_closed);
      compare("close_status", e.close_status, got.close_status);
      compare("next_request", e.next_request, got.next_request);
      compare("good_frames", e.good_frames, got.good_frames);
      compare("bad_frames", e.bad_frames, got.bad_frames);
      compare("underruns", e.underruns, got.underruns);
      compare("bytes_taken", e.bytes_taken, got.bytes_taken);
      compare("bytes_dropped", e.bytes_dropped, got.bytes_dropped);
    endfunction
  endclass

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [23:0]  s_axis_tdata_i  = '0;
  logic [1:0]   s_axis_tuser_i  = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b1;
  logic [255:0] m_axis_tdata_o;
  logic         cfg_valid_i     = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i     = '0;
  logic [31:0]  cfg_data_i      = '0;

  reassembly_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned random_items = 0;

  video_frame_packet_reassembler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: check accepted beats, stall in short bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(vfpr_pkg::out_beat_t'(m_axis_tdata_o));
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Hold tvalid high after acceptance; the next call either keeps it or drops it for a gap.
  task automatic send_beat(vfpr_pkg::kind_e kind, logic [vfpr_pkg::REQ_W-1:0] count,
                           logic failed, logic ready);
    vfpr_pkg::in_beat_t beat;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    beat.pad             = 1'b0;
    beat.buffer_ready    = ready;
    beat.transfer_failed = failed;
    beat.byte_count      = count;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= beat;
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_transfer(kind, count, failed, ready);
    if (!failed && kind != vfpr_pkg::KIND_OTHER) random_items++;
  endtask

  task automatic send_noise();
    send_beat(vfpr_pkg::kind_e'($urandom_range(0, 3)),
              vfpr_pkg::REQ_W'($urandom_range(0, 21'h1FFFFF)),
              $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
  endtask

  // Drain every outstanding result, then allow for the two-stage pipeline.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; apply_config drops it once.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(logic [31:0] frame, logic [31:0] chunk, logic [31:0] tail,
                              bit touch_unused);
    write_reg(vfpr_pkg::CFG_FRAME_BYTES, frame);
    write_reg(vfpr_pkg::CFG_CHUNK_BYTES, chunk);
    write_reg(vfpr_pkg::CFG_TAIL_BYTES, tail);
    if (touch_unused) write_reg(CFG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  // One leader / data / trailer run, sized from the predicted request, with some breakage.
  task automatic run_frame();
    int unsigned                n_data;
    logic [vfpr_pkg::REQ_W-1:0] r;
    logic [vfpr_pkg::REQ_W-1:0] cnt;
    send_beat(vfpr_pkg::KIND_LEADER, vfpr_pkg::REQ_W'($urandom_range(0, 255)),
              $urandom_range(0, 19) == 0, $urandom_range(0, 9) != 0);
    n_data = $urandom_range(0, 8);
    for (int i = 0; i < n_data && !sb.frame_filled(); i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      r = sb.request_size();
      case ($urandom_range(0, 9))
        0:       cnt = vfpr_pkg::REQ_W'($urandom_range(0, 32'(r)));
        1:       cnt = r + vfpr_pkg::REQ_W'($urandom_range(1, 64));
        default: cnt = r;
      endcase
      send_beat(vfpr_pkg::KIND_DATA, cnt, $urandom_range(0, 19) == 0,
                1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) != 0)
      send_beat(vfpr_pkg::KIND_TRAILER,
                ($urandom_range(0, 3) == 0) ? vfpr_pkg::REQ_W'($urandom_range(0, 21'h1FFFFF))
                                            : sb.request_size(),
                $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [31:0] chunk;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values first.
    run_frame();
    run_frame();
    settle();

    apply_config(32'd4000, 32'd1500, 32'd64, 1'b0);
    send_beat(vfpr_pkg::KIND_TRAILER, 21'd64, 1'b0, 1'b1);     // no frame open: ignored
    send_beat(vfpr_pkg::KIND_DATA, 21'h1FFFFF, 1'b0, 1'b1);    // no frame open: dropped
    send_beat(vfpr_pkg::KIND_OTHER, 21'h155555, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_LEADER, 21'h1FFFFF, 1'b0, 1'b0);  // underrun
    send_beat(vfpr_pkg::KIND_LEADER, 21'd0, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd1500, 1'b0, 1'b0);
    send_beat(vfpr_pkg::KIND_DATA, 21'd1500, 1'b1, 1'b1);      // errored transfer
    send_beat(vfpr_pkg::KIND_DATA, 21'd1500, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd1000, 1'b0, 1'b1);      // fills the frame exactly
    send_beat(vfpr_pkg::KIND_TRAILER, 21'd64, 1'b0, 1'b0);     // success
    send_beat(vfpr_pkg::KIND_LEADER, 21'h0AAAAA, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd4001, 1'b0, 1'b1);      // too big: mismatch
    send_beat(vfpr_pkg::KIND_DATA, 21'd10, 1'b0, 1'b1);        // mismatched frame: dropped
    send_beat(vfpr_pkg::KIND_TRAILER, 21'd64, 1'b0, 1'b1);     // size mismatch
    send_beat(vfpr_pkg::KIND_LEADER, 21'd5, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd3999, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd1, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_DATA, 21'd1, 1'b0, 1'b1);         // past the end of a full frame
    send_beat(vfpr_pkg::KIND_TRAILER, 21'd64, 1'b1, 1'b1);     // errored trailer
    send_beat(vfpr_pkg::KIND_TRAILER, 21'd64, 1'b0, 1'b1);     // judged by offset only
    send_beat(vfpr_pkg::KIND_LEADER, 21'd1, 1'b0, 1'b1);
    send_beat(vfpr_pkg::KIND_LEADER, 21'd2, 1'b0, 1'b1);       // closes open frame as missing
    send_beat(vfpr_pkg::KIND_LEADER, 21'd3, 1'b0, 1'b0);       // missing and underrun together
    send_beat(vfpr_pkg::KIND_LEADER, 21'd0, 1'b1, 1'b1);
    send_beat(vfpr_pkg::KIND_OTHER, 21'd0, 1'b1, 1'b0);
    settle();

    random_items = 0;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: apply_config(32'd1, 32'd1, 32'd1, 1'b0);
        1: apply_config(32'hFFFF_FFFF, 32'd1048576, 32'd1048576, 1'b0);
        2: apply_config(32'd0, 32'd0, 32'd0, 1'b0);
        3: apply_config($urandom_range(1, 20000), 32'hFFFF_FFFF, 32'h001F_FFFF, 1'b1);
        4: apply_config($urandom_range(1, 20000), 32'd0, $urandom_range(1, 1048576), 1'b0);
        default: begin
          chunk = $urandom_range(1, 4096);
          apply_config(chunk * $urandom_range(0, 5) + $urandom_range(1, chunk), chunk,
                       $urandom_range(1, 1048576), 1'b0);
        end
      endcase
      idle_on = (p != 9);
      while (random_items < (p + 1) * 115) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else run_frame();
        if (p != 9 && $urandom_range(0, 9) == 0) idle_on = !idle_on;
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/vfpr_pkg.sv
rtl/video_frame_packet_reassembler_top.sv
tb/sv/tb_video_frame_packet_reassembler_top.sv
